### rtl/alr_pkg.sv
`timescale 1ns / 1ps

package alr_pkg;

    // Field widths
    localparam int SAMPLE_W     = 16;
    localparam int REQ_W        = 7;
    localparam int REG_W        = 15;
    localparam int OPCODE_W     = 2;

    // Defaults
    localparam int CAPACITY_DEF = 16384;
    localparam logic [REG_W-1:0] TARGET_RST    = 15'd1336;
    localparam logic [REG_W-1:0] HIGHWATER_RST = 15'd4410;
    localparam logic [REQ_W-1:0] MAX_REQ       = 7'd64;

    // Opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_TARGET    = 1'b0,
        REG_HIGHWATER = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [OPCODE_W-1:0]        opcode;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [REQ_W-1:0]           req_limit;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       is_last;
        logic                       none_available;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_EMPTY
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic mem_re;
        logic load_sample;
        logic load_empty;
    } t_ctl_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic op_read;
        logic rd_empty;
        logic last;
        logic slot_free;
    } t_ctl_sts;

endpackage

### rtl/alr_ram.sv
`timescale 1ns / 1ps

module alr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/alr_ctrl.sv
`timescale 1ns / 1ps

module alr_ctrl
    import alr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_sts.op_read) begin
                    n_state = i_sts.rd_empty ? ST_EMPTY : ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_sts.slot_free) begin
                    n_state = i_sts.last ? ST_IDLE : ST_FETCH;
                end
            end
            ST_EMPTY: begin
                if (i_sts.slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd             = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_FETCH: begin
                o_cmd.mem_re = 1'b1;
            end
            ST_LOAD: begin
                o_cmd.load_sample = i_sts.slot_free;
            end
            ST_EMPTY: begin
                o_cmd.load_empty = i_sts.slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/alr_dp.sv
`timescale 1ns / 1ps

module alr_dp
    import alr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_beat         i_in_data,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_out_beat        o_out_data,
    input  t_ctl_cmd         i_cmd,
    output t_ctl_sts         o_sts
);

    localparam int PW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > REG_W) ? CNT_W : REG_W;
    localparam logic [PW:0]      CAP_EXT  = (PW + 1)'(CAPACITY);
    localparam logic [PW-1:0]    PTR_LAST = PW'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    logic [REG_W-1:0] r_target;
    logic [REG_W-1:0] r_high;
    logic [PW-1:0]    r_head;
    logic [CNT_W-1:0] r_count;
    logic             r_primed;
    logic [PW-1:0]    r_pos;
    logic [REQ_W-1:0] r_left;
    logic             r_out_valid;
    t_out_beat        r_out;

    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] tgt_x;
    logic [CMP_W-1:0] hw_x;
    logic [CMP_W-1:0] tc_x;
    logic [CNT_W-1:0] tc;
    logic             short_fill;
    logic [REQ_W-1:0] req;
    logic [REQ_W-1:0] take;
    logic [CNT_W-1:0] rd_count;
    logic             rd_primed;
    logic [PW:0]      start_sum;
    logic [PW-1:0]    start_pos;
    logic [PW-1:0]    head_nxt;
    logic [PW-1:0]    pos_nxt;
    logic [SAMPLE_W-1:0] mem_rdata;
    logic             is_push;
    logic             is_read;
    logic             is_clear;

    assign is_push  = (i_in_data.opcode == OP_PUSH);
    assign is_read  = (i_in_data.opcode == OP_READ);
    assign is_clear = (i_in_data.opcode == OP_CLEAR);

    // Trim, priming check and read length
    always_comb begin
        cnt_x      = CMP_W'(r_count);
        tgt_x      = CMP_W'(r_target);
        hw_x       = CMP_W'(r_high);
        tc_x       = (cnt_x > hw_x && tgt_x < cnt_x) ? tgt_x : cnt_x;
        tc         = tc_x[CNT_W-1:0];
        short_fill = !r_primed && (tc_x < tgt_x);
        req        = (i_in_data.req_limit > MAX_REQ) ? MAX_REQ : i_in_data.req_limit;
        take       = (CMP_W'(req) < tc_x) ? req : tc_x[REQ_W-1:0];
        if (short_fill) begin
            take = '0;
        end
        rd_count   = tc - CNT_W'(take);
        rd_primed  = !short_fill && (rd_count != '0);
    end

    // Oldest sample sits count entries behind the head
    always_comb begin
        start_sum = {1'b0, r_head} + CAP_EXT - (PW + 1)'(tc);
        if (start_sum >= CAP_EXT) begin
            start_sum = start_sum - CAP_EXT;
        end
        start_pos = start_sum[PW-1:0];
    end

    assign head_nxt = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
    assign pos_nxt  = (r_pos == PTR_LAST) ? '0 : r_pos + 1'b1;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
            r_high   <= HIGHWATER_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_TARGET) begin
                r_target <= i_cfg_data;
            end else begin
                r_high <= i_cfg_data;
            end
        end
    end

    // Ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_primed <= 1'b0;
        end else if (i_cmd.accept) begin
            if (is_push) begin
                r_head <= head_nxt;
                if (r_count != CNT_FULL) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (is_clear) begin
                r_head   <= '0;
                r_count  <= '0;
                r_primed <= 1'b0;
            end else if (is_read) begin
                r_count  <= rd_count;
                r_primed <= rd_primed;
            end
        end
    end

    // Read walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_cmd.accept && is_read) begin
            r_left <= take;
        end else if (i_cmd.load_sample) begin
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_read) begin
            r_pos <= start_pos;
        end else if (i_cmd.load_sample) begin
            r_pos <= pos_nxt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_sample || i_cmd.load_empty) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_out.sample_out     <= mem_rdata;
            r_out.is_last        <= (r_left == REQ_W'(1));
            r_out.none_available <= 1'b0;
        end else if (i_cmd.load_empty) begin
            r_out.sample_out     <= '0;
            r_out.is_last        <= 1'b1;
            r_out.none_available <= 1'b1;
        end
    end

    alr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && is_push),
        .i_waddr (r_head),
        .i_wdata (i_in_data.sample_in),
        .i_re    (i_cmd.mem_re),
        .i_raddr (r_pos),
        .o_rdata (mem_rdata)
    );

    // Status to controller
    always_comb begin
        o_sts.op_read   = is_read;
        o_sts.rd_empty  = (take == '0);
        o_sts.last      = (r_left == REQ_W'(1));
        o_sts.slot_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/audio_latency_ring.sv
`timescale 1ns / 1ps
// Channel   Signals                              Beat
// ------    -----------------------------------  --------------------------------
// in        i_in_valid / o_in_ready / i_in_data  opcode, sample_in, req_limit
// out       o_out_valid / i_out_ready / o_out_data  sample_out, is_last, none_available
// cfg       i_cfg_we / i_cfg_idx / i_cfg_data    0 target_level, 1 highwater_level
//
// Push, clear and ignored opcodes are accepted in the idle state. An accepted
// read then alternates a RAM fetch and a load of the output register for each
// delivered sample; an empty read gives one beat. Input is taken only once the
// previous read has handed its last beat to the output register.
// Synchronous reset clears head pointer, count and primed flag and restores
// the level registers; the sample RAM is not cleared. A stalled output holds
// the walker in place.

module audio_latency_ring
    import alr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_beat        o_out_data,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    alr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    alr_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import alr_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEF;
    localparam int STALL_MAX  = 5000;   // cycles with no beat moving before giving up
    localparam int HOLD_LONG  = 400;    // long output hold-off for the backpressure test
    localparam int REQ_CAP    = 64;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_beat         i_in_data  = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_beat        o_out_data;
    logic             i_cfg_we   = 1'b0;
    logic [0:0]       i_cfg_idx  = REG_TARGET;
    logic [REG_W-1:0] i_cfg_data = '0;

    // Shadow of the ring and its levels
    logic [SAMPLE_W-1:0] ring_mem [CAPACITY];
    int wr_head;
    int fill_level;
    int lvl_target;
    int lvl_highwater;
    bit is_primed;

    t_out_beat playback_q[$];
    t_out_beat want_beat;
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 10;
    int recv_stall_pct = 49;
    int hold_left      = 0;

    audio_latency_ring u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Queue a playback beat
    task automatic queue_beat(input logic [SAMPLE_W-1:0] s, input bit last, input bit none);
        t_out_beat b;
        b.sample_out     = s;
        b.is_last        = last;
        b.none_available = none;
        playback_q.push_back(b);
    endtask

    // Advance the shadow ring by one accepted beat and queue what it plays out
    task automatic ring_step(input t_in_beat b);
        int req;
        int n;
        int pos;
        case (b.opcode)
            OP_PUSH: begin
                ring_mem[wr_head] = b.sample_in;
                wr_head = (wr_head + 1) % CAPACITY;
                if (fill_level < CAPACITY) fill_level++;
            end
            OP_CLEAR: begin
                wr_head    = 0;
                fill_level = 0;
                is_primed  = 1'b0;
            end
            OP_READ: begin
                req = int'(b.req_limit);
                if (req > REQ_CAP) req = REQ_CAP;
                // trim to the cushion, never upward
                if (fill_level > lvl_highwater && lvl_target < fill_level)
                    fill_level = lvl_target;
                if (!is_primed) begin
                    if (fill_level < lvl_target) begin
                        queue_beat('0, 1'b1, 1'b1);
                        return;
                    end
                    is_primed = 1'b1;
                end
                n   = (req < fill_level) ? req : fill_level;
                pos = (wr_head + CAPACITY - fill_level) % CAPACITY;
                for (int i = 0; i < n; i++) begin
                    queue_beat(ring_mem[pos], i + 1 == n, 1'b0);
                    pos = (pos + 1) % CAPACITY;
                end
                fill_level -= n;
                if (fill_level == 0) is_primed = 1'b0;
                if (n == 0) queue_beat('0, 1'b1, 1'b1);
            end
            default: ;
        endcase
    endtask

    // Score output beats, then fold accepted input beats into the shadow
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (playback_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected beat, expected none, got sample %0d last %0b none %0b",
                             $time, o_out_data.sample_out, o_out_data.is_last,
                             o_out_data.none_available);
                end else begin
                    want_beat = playback_q.pop_front();
                    if (want_beat.sample_out !== o_out_data.sample_out ||
                        want_beat.is_last !== o_out_data.is_last ||
                        want_beat.none_available !== o_out_data.none_available) begin
                        mismatch_count++;
                        $display("%0t ns: beat mismatch, expected sample %0d last %0b none %0b, got sample %0d last %0b none %0b",
                                 $time, want_beat.sample_out, want_beat.is_last,
                                 want_beat.none_available, o_out_data.sample_out,
                                 o_out_data.is_last, o_out_data.none_available);
                    end
                end
            end
            if (i_in_valid && o_in_ready) ring_step(i_in_data);
        end
    end

    // Output side: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one input beat and hold it until accepted
    task automatic offer_beat(input t_in_beat b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic push_sample(input int s);
        t_in_beat b;
        b.opcode    = OP_PUSH;
        b.sample_in = SAMPLE_W'(s);
        b.req_limit = REQ_W'($urandom_range(0, 127));
        offer_beat(b);
    endtask

    task automatic request(input int m);
        t_in_beat b;
        b.opcode    = OP_READ;
        b.sample_in = SAMPLE_W'($urandom_range(0, 65535));
        b.req_limit = REQ_W'(m);
        offer_beat(b);
    endtask

    task automatic clear_ring();
        t_in_beat b;
        b.opcode    = OP_CLEAR;
        b.sample_in = SAMPLE_W'($urandom_range(0, 65535));
        b.req_limit = REQ_W'($urandom_range(0, 127));
        offer_beat(b);
    endtask

    task automatic unused_op();
        t_in_beat b;
        b.opcode    = OP_UNUSED;
        b.sample_in = SAMPLE_W'($urandom_range(0, 65535));
        b.req_limit = REQ_W'($urandom_range(0, 127));
        offer_beat(b);
    endtask

    // Stop sending and wait until every queued beat has played out
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (playback_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= REG_W'(val);
        @(posedge i_clk);
        case (idx)
            REG_TARGET:    lvl_target    = val & 32'h7FFF;
            REG_HIGHWATER: lvl_highwater = val & 32'h7FFF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_levels(input int tgt, input int hw);
        settle();
        write_reg(REG_TARGET, tgt);
        write_reg(REG_HIGHWATER, hw);
    endtask

    function automatic int rand_req();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return 0;
        if (pick < 25) return $urandom_range(REQ_CAP + 1, 127);
        return $urandom_range(1, REQ_CAP);
    endfunction

    // Reset levels: the ring cannot prime with a handful of samples
    task automatic test_reset_defaults();
        request(64);
        push_sample(123);
        push_sample(-456);
        push_sample(789);
        request(64);
        unused_op();
        clear_ring();
        request(127);
    endtask

    // Sample extremes, zero and oversized requests, running dry
    task automatic test_basic_extremes();
        set_levels(4, 40);
        push_sample(-32768);
        push_sample(32767);
        push_sample(0);
        push_sample(-1);
        push_sample(16'h5555);
        push_sample(-21846);
        request(0);
        request(2);
        request(127);
        request(64);
        push_sample(77);
        request(1);
    endtask

    task automatic test_zero_target();
        set_levels(0, 16384);
        clear_ring();
        request(5);
        push_sample(11);
        push_sample(-22);
        push_sample(33);
        request(2);
        request(64);
        request(64);
    endtask

    task automatic test_unreachable_target();
        set_levels(16384, 0);
        repeat (5) push_sample($urandom_range(0, 65535));
        request(64);
        clear_ring();
    endtask

    // Trim of an unprimed ring, of a primed ring, and a trim that would raise the count
    task automatic test_trim();
        set_levels(3, 8);
        repeat (10) push_sample($urandom_range(0, 65535));
        request(64);
        repeat (5) push_sample($urandom_range(0, 65535));
        request(1);
        repeat (6) push_sample($urandom_range(0, 65535));
        request(64);
        set_levels(10, 2);
        clear_ring();
        repeat (5) push_sample($urandom_range(0, 65535));
        request(64);
    endtask

    // Long output stall while the input keeps offering beats
    task automatic test_backpressure();
        set_levels(2, 200);
        clear_ring();
        hold_left = HOLD_LONG;
        repeat (40) push_sample($urandom_range(0, 65535));
        request(8);
        request(8);
        repeat (5) push_sample($urandom_range(0, 65535));
        request(64);
        request(64);
        settle();
    endtask

    // Push bursts followed by reads, with clears and unused opcodes mixed in
    task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
        int tgt;
        int hw;
        int counted;
        int pick;
        int burst;
        tgt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16384) : $urandom_range(0, 40);
        hw  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16384)
                                          : tgt + $urandom_range(0, 80);
        set_levels(tgt, hw);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        counted = 0;
        while (counted < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                burst = $urandom_range(1, 24);
                repeat (burst) push_sample($urandom_range(0, 65535));
                counted += burst;
                burst = $urandom_range(1, 3);
                repeat (burst) request(rand_req());
                counted += burst;
            end else if (pick < 80) begin
                request(rand_req());
                counted++;
            end else if (pick < 88) begin
                clear_ring();
                counted++;
            end else if (pick < 94) begin
                unused_op();
            end else begin
                push_sample($urandom_range(0, 65535));
                counted++;
            end
        end
    endtask

    initial begin
        wr_head       = 0;
        fill_level    = 0;
        is_primed     = 1'b0;
        lvl_target    = int'(TARGET_RST);
        lvl_highwater = int'(HIGHWATER_RST);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_basic_extremes();
        test_zero_target();
        test_unreachable_target();
        test_trim();
        test_backpressure();
        test_random_traffic(80, 10, 49);
        test_random_traffic(80, 49, 10);
        test_random_traffic(80, 0, 0);

        settle();
        repeat (20) @(posedge i_clk);
        if (playback_q.size() != 0) begin
            mismatch_count++;
            $display("%0t ns: %0d expected beats never arrived", $time, playback_q.size());
        end
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/alr_pkg.sv
rtl/alr_ram.sv
rtl/alr_ctrl.sv
rtl/alr_dp.sv
rtl/audio_latency_ring.sv
verif/tb.sv
